// File: rtl/fvs_pkg.sv
// shared types, constants and float helpers of the float vector statistics core
`default_nettype none
package fvs_pkg;

  localparam int unsigned DblW     = 64;
  localparam int unsigned SglW     = 32;
  localparam int unsigned DivSteps = 56;

  // one classified element as it travels from the front to the back
  typedef struct packed {
    logic            last;
    logic            add_en;
    logic [DblW-1:0] sum_op;
    logic [DblW-1:0] abs_op;
    logic [SglW-1:0] min_v;
    logic [SglW-1:0] max_v;
  } fvs_item_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ADD,
    B_DSTART,
    B_DWAIT,
    B_FIN
  } back_state_e;

  // single compare a < b, false when either is nan, zeros equal
  function automatic logic fp_lt(input logic [31:0] a, input logic [31:0] b);
    logic an;
    logic bn;
    logic r;
    an = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
    bn = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    if (an || bn) begin
      r = 1'b0;
    end else if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      r = 1'b0;
    end else if (a[31] != b[31]) begin
      r = a[31];
    end else if (!a[31]) begin
      r = a[30:0] < b[30:0];
    end else begin
      r = a[30:0] > b[30:0];
    end
    return r;
  endfunction

  // exact widening of a finite single to double
  function automatic logic [63:0] sgl_to_dbl(input logic [31:0] w);
    logic [4:0]  p;
    logic [22:0] fr;
    logic [10:0] e;
    logic [63:0] r;
    p  = 5'd0;
    fr = 23'd0;
    for (int i = 0; i < 23; i++) begin
      if (w[i]) p = 5'(i);
    end
    if (w[30:23] == 8'd0) begin
      if (w[22:0] == 23'd0) begin
        r = {w[31], 63'd0};
      end else begin
        fr = w[22:0] << (5'd23 - p);
        e  = 11'd874 + 11'(p);
        r  = {w[31], e, fr, 29'd0};
      end
    end else begin
      e = 11'(w[30:23]) + 11'd896;
      r = {w[31], e, w[22:0], 29'd0};
    end
    return r;
  endfunction

  // round a double (unbiased exponent, 53 bit mantissa) to single, nearest even
  function automatic logic [31:0] dbl_narrow(input logic sgn, input logic zero,
                                             input logic signed [13:0] e,
                                             input logic [52:0] m);
    logic [31:0] r;
    logic [6:0]  rs;
    logic [52:0] f;
    logic [52:0] lo;
    logic        g;
    logic        st;
    r  = {sgn, 31'd0};
    rs = 7'd0;
    f  = 53'd0;
    lo = 53'd0;
    g  = 1'b0;
    st = 1'b0;
    if (zero) begin
      r = {sgn, 31'd0};
    end else if (e > 14'sd127) begin
      r = {sgn, 8'hFF, 23'd0};
    end else if (e >= -14'sd126) begin
      g  = m[28];
      st = |m[27:0];
      r  = {sgn, 8'(e + 14'sd127), m[51:29]} + 32'(g & (st | m[29]));
    end else begin
      rs = 7'(-e - 14'sd97);
      if (rs <= 7'd54) begin
        f  = m >> rs;
        lo = m >> (rs - 7'd1);
        g  = lo[0];
        st = (m & ((53'd1 << (rs - 7'd1)) - 53'd1)) != 53'd0;
        r  = {sgn, 31'(f)} + 32'(g & (st | f[0]));
      end
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/fvs_fifo.sv
// two entry request queue between front and back
`default_nettype none
module fvs_fifo #(
  parameter int unsigned W = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] din_i,
  output logic              full_o,
  input  wire logic         pop_i,
  output logic              empty_o,
  output logic [W-1:0]      dout_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, rp_q;
  logic [1:0]   cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign dout_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= din_i;
  end
endmodule
`default_nettype wire

// File: rtl/fvs_front.sv
// front: classifies elements, tracks min, max and counts, forms the queue items
`default_nettype none
module fvs_front
  import fvs_pkg::*;
#(
  parameter int unsigned MAX_ELEMS = 4096,
  parameter int unsigned CW        = 13
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            acc_i,
  input  wire logic [31:0]     value_i,
  input  wire logic            last_i,
  output fvs_item_t            item_o,
  output logic [4*CW-1:0]      cnts_o
);
  logic          first_q;
  logic [31:0]   min_q, max_q, min_d, max_d;
  logic [CW-1:0] nan_q, inf_q, nz_q, el_q;
  logic [CW-1:0] nan_d, inf_d, nz_d, el_d;
  logic          special, is_nan;

  function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] c);
    return (c < CW'(MAX_ELEMS)) ? c + CW'(1) : c;
  endfunction

  always_comb begin
    special = value_i[30:23] == 8'hFF;
    is_nan  = special && (value_i[22:0] != 23'd0);
    min_d   = first_q ? value_i : min_q;
    max_d   = first_q ? value_i : max_q;
    el_d    = sat_inc(el_q);
    nan_d   = (special && is_nan) ? sat_inc(nan_q) : nan_q;
    inf_d   = (special && !is_nan) ? sat_inc(inf_q) : inf_q;
    nz_d    = nz_q;
    if (!special) begin
      if (fp_lt(value_i, min_d)) min_d = value_i;
      if (fp_lt(max_d, value_i)) max_d = value_i;
      if (value_i[30:0] != 31'd0) nz_d = sat_inc(nz_q);
    end
    item_o.last   = last_i;
    item_o.add_en = !special;
    item_o.sum_op = sgl_to_dbl(value_i);
    item_o.abs_op = sgl_to_dbl({1'b0, value_i[30:0]});
    item_o.min_v  = min_d;
    item_o.max_v  = max_d;
    cnts_o        = {el_d, nz_d, inf_d, nan_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= 1'b1;
      min_q   <= '0;
      max_q   <= '0;
      nan_q   <= '0;
      inf_q   <= '0;
      nz_q    <= '0;
      el_q    <= '0;
    end else if (acc_i) begin
      if (last_i) begin
        first_q <= 1'b1;
        min_q   <= '0;
        max_q   <= '0;
        nan_q   <= '0;
        inf_q   <= '0;
        nz_q    <= '0;
        el_q    <= '0;
      end else begin
        first_q <= 1'b0;
        min_q   <= min_d;
        max_q   <= max_d;
        nan_q   <= nan_d;
        inf_q   <= inf_d;
        nz_q    <= nz_d;
        el_q    <= el_d;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/fvs_dadd.sv
// four step double adder, round to nearest even, normal operands or zero
`default_nettype none
module fvs_dadd
  import fvs_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] a_i,
  input  wire logic [63:0] b_i,
  output logic             done_o,
  output logic [63:0]      res_o
);
  logic        busy_q;
  logic [1:0]  st_q;
  logic        byp_q, sgn_q, sub_q, top_q;
  logic [63:0] byp_res_q;
  logic [55:0] big_q, sml_q;
  logic [11:0] e_q;
  logic [56:0] sum_q;
  logic [5:0]  lz_q;

  // alignment, combinational on the start cycle, then normalization and rounding of the registered sum
  logic        az, bz, a_ge;
  logic [63:0] bg, sm;
  logic [10:0] dsh;
  logic [55:0] sext, smask, sal;
  logic [5:0]  lz;
  logic [55:0] nm;
  logic [52:0] m53;
  logic        up;
  logic [11:0] er;

  always_comb begin
    az    = a_i[62:52] == 11'd0;
    bz    = b_i[62:52] == 11'd0;
    a_ge  = a_i[62:0] >= b_i[62:0];
    bg    = a_ge ? a_i : b_i;
    sm    = a_ge ? b_i : a_i;
    dsh   = bg[62:52] - sm[62:52];
    sext  = {1'b1, sm[51:0], 3'b000};
    smask = (dsh >= 11'd56) ? {56{1'b1}} : ~({56{1'b1}} << dsh[5:0]);
    sal   = (dsh >= 11'd56) ? 56'd0 : (sext >> dsh[5:0]);
    sal[0] = sal[0] | ((sext & smask) != 56'd0);
    lz = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (sum_q[i]) lz = 6'(55 - i);
    end
    if (top_q) begin
      nm = sum_q[56:1] | {55'd0, sum_q[0]};
      er = e_q + 12'd1;
    end else begin
      nm = sum_q[55:0] << lz_q;
      er = e_q - 12'(lz_q);
    end
    m53 = nm[55:3];
    up  = nm[2] & (nm[1] | nm[0] | m53[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      st_q   <= 2'd0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        st_q   <= 2'd1;
      end else if (busy_q) begin
        st_q <= st_q + 2'd1;
        if (st_q == 2'd3) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      byp_q     <= az || bz;
      byp_res_q <= az ? (bz ? {a_i[63] & b_i[63], 63'd0} : b_i) : a_i;
      sgn_q     <= bg[63];
      sub_q     <= a_i[63] ^ b_i[63];
      big_q     <= {1'b1, bg[51:0], 3'b000};
      sml_q     <= sal;
      e_q       <= {1'b0, bg[62:52]};
    end
    if (busy_q && st_q == 2'd1) begin
      sum_q <= sub_q ? ({1'b0, big_q} - {1'b0, sml_q}) : ({1'b0, big_q} + {1'b0, sml_q});
    end
    if (busy_q && st_q == 2'd2) begin
      top_q <= sum_q[56];
      lz_q  <= lz;
    end
    if (busy_q && st_q == 2'd3) begin
      if (byp_q) begin
        res_o <= byp_res_q;
      end else if (sum_q == 57'd0) begin
        res_o <= 64'd0;
      end else begin
        res_o <= {sgn_q, er[10:0], m53[51:0]} + 64'(up);
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/fvs_div.sv
// bit serial divider of a double by an integer count, rounded to double
`default_nettype none
module fvs_div
  import fvs_pkg::*;
#(
  parameter int unsigned CW = 13
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [63:0]   sum_i,
  input  wire logic [CW-1:0] cnt_i,
  output logic               done_o,
  output logic               sign_o,
  output logic signed [13:0] exp_o,
  output logic [52:0]        mant_o
);
  localparam int unsigned MW = (CW > 1) ? $clog2(CW) : 1;

  logic               busy_q, fin_q, sign_q;
  logic [5:0]         step_q;
  logic [53:0]        r_q;
  logic [52:0]        d_q;
  logic [55:0]        q_q;
  logic signed [13:0] e_q;

  logic [MW-1:0]      msb;
  logic               ge;
  logic [53:0]        rn;
  logic               lead, g, st, up;
  logic [52:0]        m;
  logic [53:0]        mr;
  logic signed [13:0] ef;

  always_comb begin
    msb = '0;
    for (int i = 0; i < CW; i++) begin
      if (cnt_i[i]) msb = MW'(i);
    end
    ge   = r_q >= {1'b0, d_q};
    rn   = ge ? r_q - {1'b0, d_q} : r_q;
    lead = q_q[55];
    m    = lead ? q_q[55:3] : q_q[54:2];
    g    = lead ? q_q[2] : q_q[1];
    st   = (lead ? (q_q[1] | q_q[0]) : q_q[0]) | (r_q != 54'd0);
    up   = g & (st | m[0]);
    mr   = {1'b0, m} + 54'(up);
    ef   = lead ? e_q : e_q - 14'sd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      fin_q  <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 6'd1;
        if (step_q == 6'(DivSteps - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end
      if (fin_q) done_o <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sign_q <= sum_i[63];
      d_q    <= 53'(cnt_i) << (6'd52 - 6'(msb));
      r_q    <= {2'b01, sum_i[51:0]};
      q_q    <= '0;
      e_q    <= $signed({3'b000, sum_i[62:52]}) - 14'sd1023 - $signed(14'(msb));
    end else if (busy_q) begin
      r_q <= {rn[52:0], 1'b0};
      q_q <= {q_q[54:0], ge};
    end
    if (fin_q) begin
      sign_o <= sign_q;
      if (mr[53]) begin
        mant_o <= {1'b1, 52'd0};
        exp_o  <= ef + 14'sd1;
      end else begin
        mant_o <= mr[52:0];
        exp_o  <= ef;
      end
    end
  end
endmodule
`default_nettype wire

// File: rtl/fvs_back.sv
// back: accumulates sums, forms mean and totals, holds the result
`default_nettype none
module fvs_back
  import fvs_pkg::*;
#(
  parameter int unsigned CW = 13
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             empty_i,
  input  fvs_item_t             item_i,
  input  wire logic [4*CW-1:0]  cnts_i,
  output logic                  pop_o,
  output logic                  res_valid_o,
  input  wire logic             res_ready_i,
  output logic [128+3*CW-1:0]   res_o
);
  back_state_e state_q, state_d;

  logic [63:0]     sum_q, abs_q, sum_res, abs_res;
  logic            sdone, adone, start_add;
  logic            last_q, zmean_q, dstart;
  logic [31:0]     min_q, max_q;
  logic [4*CW-1:0] cnts_q;
  logic            ddone, dsign;
  logic signed [13:0] dexp;
  logic [52:0]     dmant;
  logic [31:0]     mean_bits, abs_bits;
  logic            fin_go, out_valid_q;

  assign pop_o     = (state_q == B_IDLE) && !empty_i;
  assign start_add = pop_o && item_i.add_en;
  assign dstart    = (state_q == B_DSTART) && (sum_q[62:0] != 63'd0);
  // finished result moves to the output register once it is free
  assign fin_go    = (state_q == B_FIN) && (!out_valid_q || res_ready_i);

  fvs_dadd u_sum (
    .clk_i, .rst_ni, .start_i(start_add), .a_i(sum_q), .b_i(item_i.sum_op),
    .done_o(sdone), .res_o(sum_res)
  );
  fvs_dadd u_abs (
    .clk_i, .rst_ni, .start_i(start_add), .a_i(abs_q), .b_i(item_i.abs_op),
    .done_o(adone), .res_o(abs_res)
  );
  fvs_div #(.CW(CW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .sum_i(sum_q), .cnt_i(cnts_q[4*CW-1:3*CW]),
    .done_o(ddone), .sign_o(dsign), .exp_o(dexp), .mant_o(dmant)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_o) begin
          if (item_i.add_en) state_d = B_ADD;
          else if (item_i.last) state_d = B_DSTART;
        end
      end
      B_ADD:    if (sdone) state_d = last_q ? B_DSTART : B_IDLE;
      B_DSTART: state_d = dstart ? B_DWAIT : B_FIN;
      B_DWAIT:  if (ddone) state_d = B_FIN;
      B_FIN:    if (fin_go) state_d = B_IDLE;
      default:  state_d = B_IDLE;
    endcase
    // a zero sum is always positive zero
    mean_bits = dbl_narrow(dsign & !zmean_q, zmean_q, dexp, dmant);
    abs_bits  = dbl_narrow(1'b0, abs_q[62:0] == 63'd0,
                           $signed({3'b000, abs_q[62:52]}) - 14'sd1023,
                           {1'b1, abs_q[51:0]});
  end

  assign res_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      sum_q       <= '0;
      abs_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (sdone) sum_q <= sum_res;
      if (adone) abs_q <= abs_res;
      if (fin_go) begin
        sum_q <= '0;
        abs_q <= '0;
      end
      if (fin_go) out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      last_q <= item_i.last;
      min_q  <= item_i.min_v;
      max_q  <= item_i.max_v;
      cnts_q <= cnts_i;
    end
    if (state_q == B_DSTART) zmean_q <= !dstart;
    if (fin_go) begin
      res_o <= {cnts_q[3*CW-1:0], abs_bits, mean_bits, max_q, min_q};
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == B_IDLE) else $error("pop outside idle");
  a_add_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sdone |-> state_q == B_ADD && adone) else $error("adder done out of step");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ddone |-> state_q == B_DWAIT) else $error("divider done out of step");
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go |=> sum_q == 64'd0 && abs_q == 64'd0) else $error("sums not cleared");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_ready_i |=> res_valid_o && $stable(res_o))
    else $error("result dropped while stalled");
`endif
endmodule
`default_nettype wire

// File: rtl/float_vector_statistics_core.sv
// top level of the float vector statistics core
`default_nettype none
// Takes a run of single-precision words on the slave stream, tlast on the final
// word, and returns one result per run on the master stream: min, max, mean,
// absolute total and the nan, infinity and nonzero counts. The front classifies
// each word in the cycle it is taken and drops it into a two-entry queue; the
// back then runs a double adder pair per finite word, one word at a time, and at
// the end of a run a 56-step serial divider for the mean, then narrows the result.
// The finished result waits in an output register, so the back can start on
// the next run while the master stream stalls.
// Nan and infinite words skip the adder.
// Counts saturate at MAX_ELEMS, and the mean divides by the saturated count.
module float_vector_statistics_core
  import fvs_pkg::*;
#(
  parameter int unsigned MAX_ELEMS = 4096
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // value_bits [31:0]
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // min_bits, max_bits, mean_bits, abs_total_bits (32 each), then nan_count,
  // inf_count, nonzero_count (CW each), zero padded to whole bytes
  output logic [((128 + 3 * $clog2(MAX_ELEMS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata
);
  localparam int unsigned CW    = $clog2(MAX_ELEMS + 1);
  localparam int unsigned RES_W = 128 + 3 * CW;
  localparam int unsigned OUT_W = ((RES_W + 7) / 8) * 8;
  localparam int unsigned ITM_W = $bits(fvs_item_t);
  localparam int unsigned Q_W   = ITM_W + 4 * CW;

  logic            full, empty, acc, pop;
  fvs_item_t       f_item, b_item;
  logic [4*CW-1:0] f_cnts;
  logic [Q_W-1:0]  q_out;
  logic [RES_W-1:0] res;

  // a word is taken whenever the queue has room
  assign s_axis_tready = !full;
  assign acc           = s_axis_tvalid && !full;

  fvs_front #(.MAX_ELEMS(MAX_ELEMS), .CW(CW)) u_front (
    .clk_i, .rst_ni, .acc_i(acc), .value_i(s_axis_tdata), .last_i(s_axis_tlast),
    .item_o(f_item), .cnts_o(f_cnts)
  );

  fvs_fifo #(.W(Q_W)) u_queue (
    .clk_i, .rst_ni, .push_i(acc), .din_i({f_cnts, f_item}), .full_o(full),
    .pop_i(pop), .empty_o(empty), .dout_o(q_out)
  );

  assign b_item = q_out[ITM_W-1:0];

  fvs_back #(.CW(CW)) u_back (
    .clk_i, .rst_ni, .empty_i(empty), .item_i(b_item), .cnts_i(q_out[Q_W-1:ITM_W]),
    .pop_o(pop), .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  // zero pad up to a byte boundary
  assign m_axis_tdata = OUT_W'(res);
endmodule
`default_nettype wire
